[src/pstb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pstb_pkg
// Types and codes shared by the periodic soft timer bank and its channels.
// ---------------------------------------------------------------------------
package pstb_pkg;

	localparam int ACTION_W  = 2;
	localparam int SLOT_W    = 3;
	localparam int WORD_W    = 32;
	localparam int KIND_W    = 2;

	// at most this many fire transactions per tick
	localparam int MAX_RESULTS = 8;
	localparam int FCNT_W      = $clog2(MAX_RESULTS + 1);

	// input action codes
	localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_STOP   = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_STARTED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NO_FREE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd3;

	// handler memory entry, written only by start
	typedef struct packed {
		logic [WORD_W-1:0] handler;
		logic [WORD_W-1:0] argument;
	} hdl_rec_t;

	// timing memory entry, written by start, modify and tick reload
	typedef struct packed {
		logic [WORD_W-1:0] period;
		logic [WORD_W-1:0] deadline;
	} tmr_rec_t;

	// one result as held in the output register
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot_index;
		logic [WORD_W-1:0] handler;
		logic [WORD_W-1:0] argument;
		logic [WORD_W-1:0] tick_now;
		logic              last;
	} rsp_t;

endpackage
`default_nettype wire

[src/pstb_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pstb_if
// Valid/ready channels for timer requests and timer results.
// ---------------------------------------------------------------------------
interface pstb_req_if import pstb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [SLOT_W-1:0]   slot;
	logic [WORD_W-1:0]   period;
	logic [WORD_W-1:0]   handler;
	logic [WORD_W-1:0]   argument;

	modport source (output valid, action, slot, period, handler, argument, input ready);
	modport sink   (input valid, action, slot, period, handler, argument, output ready);
endinterface

interface pstb_rsp_if import pstb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [SLOT_W-1:0] slot_index;
	logic [WORD_W-1:0] fired_handler;
	logic [WORD_W-1:0] fired_argument;
	logic [WORD_W-1:0] tick_now;
	logic              last;

	modport source (output valid, result_kind, slot_index, fired_handler, fired_argument,
		tick_now, last, input ready);
	modport sink   (input valid, result_kind, slot_index, fired_handler, fired_argument,
		tick_now, last, output ready);
endinterface
`default_nettype wire

[src/periodic_soft_timer_bank.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// periodic_soft_timer_bank
// Bank of periodic timer slots driven by a wrapping 32-bit tick counter.
// ---------------------------------------------------------------------------
// Start, modify and stop requests each give one result transaction. A tick
// walks every slot through the slot memories at one slot per cycle unless the
// result side stalls (each slot is read into a register, then compared and
// reloaded); each firing slot up to MAX_RESULTS gives one result and the final
// one carries last. A tick with no firing slot gives no result. Requests are
// taken only while no tick is being walked and the output register is free or
// being drained.
module periodic_soft_timer_bank import pstb_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	pstb_req_if.sink    req,
	pstb_rsp_if.source  rsp
);

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t              state_q;
	logic [WORD_W-1:0]   cnt_q;
	logic [SLOT_COUNT-1:0] act_q;

	// slot memories
	hdl_rec_t            hdl_mem [SLOT_COUNT];
	tmr_rec_t            tmr_mem [SLOT_COUNT];
	hdl_rec_t            hdl_rd_s1;
	tmr_rec_t            tmr_rd_s1;
	logic [SW-1:0]       rd_addr;
	logic                hdl_we;
	logic [SW-1:0]       hdl_wa;
	hdl_rec_t            hdl_wd;
	logic                tmr_we;
	logic [SW-1:0]       tmr_wa;
	tmr_rec_t            tmr_wd;

	// scan control
	logic [SW-1:0]       ev_q;
	logic                ev_v_q;
	logic [FCNT_W-1:0]   fcnt_q;
	logic                pend_v_q;
	rsp_t                pend_q;

	// output register
	logic                out_v_q;
	rsp_t                out_q;

	logic                out_free;
	logic                acc;
	logic                free_found;
	logic [SW-1:0]       free_ix;
	logic [SW-1:0]       slot_ix;
	logic                slot_ok;
	logic                fire;
	logic                emit_new;
	logic                stall;
	logic                step;
	logic                ev_last;
	logic                out_load;
	rsp_t                out_d;
	rsp_t                fire_res;
	logic [WORD_W-1:0]   start_deadline;

	assign out_free = !out_v_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign acc = req.valid && req.ready;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_ix = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!act_q[i]) begin
				free_found = 1'b1;
				free_ix = SW'(i);
			end
		end
	end

	assign slot_ix = SW'(req.slot);
	assign slot_ok = ({29'd0, req.slot} < 32'(SLOT_COUNT)) && act_q[slot_ix];
	assign start_deadline = cnt_q + req.period;

	// slot under evaluation during a tick walk
	assign fire = (state_q == ST_SCAN) && ev_v_q && act_q[ev_q] && (tmr_rd_s1.deadline == cnt_q);
	assign emit_new = fire && (fcnt_q < FCNT_W'(MAX_RESULTS));
	assign stall = emit_new && pend_v_q && !out_free;
	assign step = (state_q == ST_SCAN) && ev_v_q && !stall;
	assign ev_last = (ev_q == SW'(SLOT_COUNT - 1));

	always_comb begin
		fire_res.kind = KIND_FIRED;
		fire_res.slot_index = 3'(ev_q);
		fire_res.handler = hdl_rd_s1.handler;
		fire_res.argument = hdl_rd_s1.argument;
		fire_res.tick_now = cnt_q;
		fire_res.last = 1'b0;
	end

	// read address: first slot on tick accept, hold on stall, else next slot
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_addr = '0;
		end else if (stall) begin
			rd_addr = ev_q;
		end else begin
			rd_addr = ev_q + SW'(1);
		end
	end

	// memory write ports
	always_comb begin
		hdl_we = acc && (req.action == ACT_START) && free_found;
		hdl_wa = free_ix;
		hdl_wd.handler = req.handler;
		hdl_wd.argument = req.argument;
		tmr_we = 1'b0;
		tmr_wa = free_ix;
		tmr_wd.period = req.period;
		tmr_wd.deadline = start_deadline;
		if (acc && (req.action == ACT_START) && free_found) begin
			tmr_we = 1'b1;
		end else if (acc && (req.action == ACT_MODIFY) && slot_ok) begin
			tmr_we = 1'b1;
			tmr_wa = slot_ix;
		end else if (step && fire) begin
			tmr_we = 1'b1;
			tmr_wa = ev_q;
			tmr_wd.period = tmr_rd_s1.period;
			tmr_wd.deadline = cnt_q + tmr_rd_s1.period;
		end
	end

	always_ff @(posedge clk) begin
		if (hdl_we) begin
			hdl_mem[hdl_wa] <= hdl_wd;
		end
		if (tmr_we) begin
			tmr_mem[tmr_wa] <= tmr_wd;
		end
		hdl_rd_s1 <= hdl_mem[rd_addr];
		tmr_rd_s1 <= tmr_mem[rd_addr];
	end

	// output register source
	always_comb begin
		out_load = 1'b0;
		out_d = pend_q;
		out_d.last = 1'b0;
		if (acc && (req.action != ACT_TICK)) begin
			out_load = 1'b1;
			out_d.handler = '0;
			out_d.argument = '0;
			out_d.tick_now = cnt_q;
			out_d.last = 1'b1;
			unique case (req.action)
				ACT_START: begin
					out_d.kind = free_found ? KIND_STARTED : KIND_NO_FREE;
					out_d.slot_index = free_found ? 3'(free_ix) : '0;
				end
				default: begin
					out_d.kind = KIND_DONE;
					out_d.slot_index = req.slot;
				end
			endcase
		end else if (step && emit_new && pend_v_q) begin
			out_load = 1'b1;
		end else if ((state_q == ST_SCAN) && !ev_v_q && pend_v_q && out_free) begin
			out_load = 1'b1;
			out_d.last = 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			act_q <= '0;
			ev_q <= '0;
			ev_v_q <= 1'b0;
			fcnt_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (req.action)
							ACT_TICK: begin
								cnt_q <= cnt_q + 32'd1;
								ev_q <= '0;
								ev_v_q <= 1'b1;
								fcnt_q <= '0;
								state_q <= ST_SCAN;
							end
							ACT_START: begin
								if (free_found) begin
									act_q[free_ix] <= (req.handler != '0);
								end
							end
							ACT_STOP: begin
								if (slot_ok) begin
									act_q[slot_ix] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (ev_v_q) begin
						if (step) begin
							if (emit_new) begin
								pend_v_q <= 1'b1;
								fcnt_q <= fcnt_q + FCNT_W'(1);
							end
							if (ev_last) begin
								ev_v_q <= 1'b0;
							end else begin
								ev_q <= ev_q + SW'(1);
							end
						end
					end else if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (step && emit_new) begin
			pend_q <= fire_res;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.result_kind = out_q.kind;
	assign rsp.slot_index = out_q.slot_index;
	assign rsp.fired_handler = out_q.handler;
	assign rsp.fired_argument = out_q.argument;
	assign rsp.tick_now = out_q.tick_now;
	assign rsp.last = out_q.last;

`ifndef NO_ASSERTIONS
	// a control request is answered by a single final transaction
	a_ctrl_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.action != ACT_TICK)) |=> (out_v_q && out_q.last))
		else $error("control request not answered");

	// never more fire transactions than the limit per tick
	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FCNT_W'(MAX_RESULTS))
		else $error("fire count over limit");

	// a pending fire only exists during a tick walk
	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q == ST_SCAN))
		else $error("pending fire outside tick walk");

	// a stalled slot is not reloaded
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> !tmr_we)
		else $error("reload during stall");
`endif

endmodule
`default_nettype wire

[test/pstb_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pstb_checker
// Watches the request and result channels of the timer bank, keeps its own
// copy of the counter and slot tables, predicts the result transactions of
// every accepted request and checks each result against them in order.
// ---------------------------------------------------------------------------
module pstb_checker import pstb_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  wire clk,
	input  wire arst_n,
	pstb_req_if req,
	pstb_rsp_if rsp,
	output int  mismatch_count,
	output int  pending_count
);

	localparam int MISMATCH_REPORTS = 10;

	// predicted state of the bank
	logic [WORD_W-1:0] tick_count;
	logic [WORD_W-1:0] handler_tbl  [SLOT_COUNT];
	logic [WORD_W-1:0] argument_tbl [SLOT_COUNT];
	logic [WORD_W-1:0] period_tbl   [SLOT_COUNT];
	logic [WORD_W-1:0] deadline_tbl [SLOT_COUNT];

	// results still to come, oldest first
	rsp_t expected_results [$];

	task automatic push_expected(input logic [KIND_W-1:0] kind, input int idx,
			input logic [WORD_W-1:0] handler, input logic [WORD_W-1:0] argument,
			input logic last);
		rsp_t entry;
		entry.kind       = kind;
		entry.slot_index = idx[SLOT_W-1:0];
		entry.handler    = handler;
		entry.argument   = argument;
		entry.tick_now   = tick_count;
		entry.last       = last;
		expected_results.push_back(entry);
	endtask

	// update the tables for one request and queue the results it causes
	task automatic predict_timer_results(input logic [ACTION_W-1:0] action,
			input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] period,
			input logic [WORD_W-1:0] handler, input logic [WORD_W-1:0] argument);
		int  fire_total;
		int  emitted;
		bit  found;
		fire_total = 0;
		emitted    = 0;
		found      = 1'b0;
		case (action)
			ACT_TICK: begin
				tick_count = tick_count + 1;
				for (int i = 0; i < SLOT_COUNT; i++)
					if (handler_tbl[i] != '0 && deadline_tbl[i] == tick_count)
						fire_total++;
				if (fire_total > MAX_RESULTS)
					fire_total = MAX_RESULTS;
				// only the lowest slots report, but every due slot reloads
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (handler_tbl[i] != '0 && deadline_tbl[i] == tick_count) begin
						if (emitted < fire_total) begin
							push_expected(KIND_FIRED, i, handler_tbl[i], argument_tbl[i],
								emitted == fire_total - 1);
							emitted++;
						end
						deadline_tbl[i] = tick_count + period_tbl[i];
					end
				end
			end
			ACT_START: begin
				for (int i = 0; i < SLOT_COUNT && !found; i++) begin
					if (handler_tbl[i] == '0) begin
						handler_tbl[i]  = handler;
						argument_tbl[i] = argument;
						period_tbl[i]   = period;
						deadline_tbl[i] = tick_count + period;
						push_expected(KIND_STARTED, i, '0, '0, 1'b1);
						found = 1'b1;
					end
				end
				if (!found)
					push_expected(KIND_NO_FREE, 0, '0, '0, 1'b1);
			end
			default: begin
				// modify or stop, acknowledged whether the slot is active or not
				if (int'(slot) < SLOT_COUNT && handler_tbl[slot] != '0) begin
					if (action == ACT_MODIFY) begin
						deadline_tbl[slot] = tick_count + period;
						period_tbl[slot]   = period;
					end else begin
						handler_tbl[slot] = '0;
					end
				end
				push_expected(KIND_DONE, int'(slot), '0, '0, 1'b1);
			end
		endcase
	endtask

	// compare one observed result with the oldest prediction
	task automatic check_result();
		rsp_t observed;
		rsp_t wanted;
		observed.kind       = rsp.result_kind;
		observed.slot_index = rsp.slot_index;
		observed.handler    = rsp.fired_handler;
		observed.argument   = rsp.fired_argument;
		observed.tick_now   = rsp.tick_now;
		observed.last       = rsp.last;
		if (expected_results.size() == 0) begin
			if (mismatch_count < MISMATCH_REPORTS)
				$display("unexpected result: kind %0d slot %0d handler %h argument %h tick %0d last %0d",
					observed.kind, observed.slot_index, observed.handler, observed.argument,
					observed.tick_now, observed.last);
			mismatch_count++;
		end else begin
			wanted = expected_results.pop_front();
			if (observed !== wanted) begin
				if (mismatch_count < MISMATCH_REPORTS) begin
					$display("result mismatch: expected kind %0d slot %0d handler %h argument %h tick %0d last %0d",
						wanted.kind, wanted.slot_index, wanted.handler, wanted.argument,
						wanted.tick_now, wanted.last);
					$display("                 actual   kind %0d slot %0d handler %h argument %h tick %0d last %0d",
						observed.kind, observed.slot_index, observed.handler, observed.argument,
						observed.tick_now, observed.last);
				end
				mismatch_count++;
			end
		end
	endtask

	// requests are predicted before results are checked within one edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count = '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				handler_tbl[i]  = '0;
				argument_tbl[i] = '0;
				period_tbl[i]   = '0;
				deadline_tbl[i] = '0;
			end
			expected_results.delete();
		end else begin
			if (req.valid === 1'b1 && req.ready === 1'b1)
				predict_timer_results(req.action, req.slot, req.period, req.handler, req.argument);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
				check_result();
		end
		pending_count = expected_results.size();
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the periodic soft timer bank with a directed opening sequence and
// then random timer traffic under varying source gaps and result back
// pressure; the checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;
	import pstb_pkg::*;

	localparam int SLOT_COUNT     = 8;
	localparam int RANDOM_ITEMS   = 420;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 4 * (SLOT_COUNT + 2);

	logic clk = 1'b0;
	logic arst_n;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   quiet_cycles = 0;
	int   mismatch_count;
	int   pending_count;

	pstb_req_if req ();
	pstb_rsp_if rsp ();

	periodic_soft_timer_bank #(.SLOT_COUNT(SLOT_COUNT)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	pstb_checker #(.SLOT_COUNT(SLOT_COUNT)) timer_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always #1 clk = ~clk;

	// result side back pressure
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req.valid === 1'b1 && req.ready === 1'b1) ||
				(rsp.valid === 1'b1 && rsp.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL periodic_soft_timer_bank");
			$finish;
		end
	end

	// present one request, with random gaps ahead of it, until it is taken
	task automatic send_request(input logic [ACTION_W-1:0] action,
			input logic [SLOT_W-1:0] slot,
			input logic [WORD_W-1:0] period, input logic [WORD_W-1:0] handler,
			input logic [WORD_W-1:0] argument);
		while ($urandom_range(0, 99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.action   <= action;
		req.slot     <= slot;
		req.period   <= period;
		req.handler  <= handler;
		req.argument <= argument;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
	endtask

	// mostly short periods so that slots fire often
	function automatic logic [WORD_W-1:0] random_period();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return $urandom();
			2:       return $urandom_range(17, 64);
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	// a zero handler now and then leaves the started slot free
	function automatic logic [WORD_W-1:0] random_handler();
		if ($urandom_range(0, 9) == 0)
			return '0;
		return $urandom();
	endfunction

	task automatic run_random_phase(input int count);
		int                sent;
		int                pick;
		logic [WORD_W-1:0] gang_period;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 48) begin
				send_request(ACT_TICK, SLOT_W'($urandom_range(0, 7)), $urandom(), $urandom(),
					$urandom());
				sent++;
			end else if (pick < 66) begin
				send_request(ACT_START, SLOT_W'($urandom_range(0, 7)), random_period(),
					random_handler(), $urandom());
				sent++;
			end else if (pick < 78) begin
				send_request(ACT_MODIFY, SLOT_W'($urandom_range(0, 7)), random_period(),
					$urandom(), $urandom());
				sent++;
			end else if (pick < 94) begin
				send_request(ACT_STOP, SLOT_W'($urandom_range(0, 7)), $urandom(), $urandom(),
					$urandom());
				sent++;
			end else begin
				// several timers armed together so they come due on the same tick
				gang_period = $urandom_range(1, 8);
				repeat (3)
					send_request(ACT_START, SLOT_W'($urandom_range(0, 7)), gang_period,
						$urandom() | 1, $urandom());
				sent += 3;
			end
		end
	endtask

	initial begin
		req.valid    = 1'b0;
		req.action   = ACT_TICK;
		req.slot     = '0;
		req.period   = '0;
		req.handler  = '0;
		req.argument = '0;
		arst_n       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// modify and stop on free slots are still acknowledged
		send_request(ACT_STOP, 3'd5, 32'd4, 32'd0, 32'd0);
		send_request(ACT_MODIFY, 3'd7, 32'd9, 32'd0, 32'd0);
		// tick with nothing due gives no result
		send_request(ACT_TICK, 3'd0, 32'd0, 32'd0, 32'd0);
		// zero handler is reported as started but the slot stays free
		send_request(ACT_START, 3'd7, 32'd2, 32'd0, 32'hFFFF_FFFF);
		// fill every slot with the same period
		send_request(ACT_START, 3'd0, 32'd2, 32'hFFFF_FFFF, 32'd0);
		send_request(ACT_START, 3'd7, 32'd2, 32'd1, 32'hFFFF_FFFF);
		repeat (SLOT_COUNT - 2)
			send_request(ACT_START, SLOT_W'($urandom_range(0, 7)), 32'd2, $urandom() | 1,
				$urandom());
		// bank full
		send_request(ACT_START, 3'd0, 32'd5, 32'hA5A5_5A5A, 32'h1234_5678);
		// all slots due together on the second tick
		send_request(ACT_TICK, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(ACT_TICK, 3'd0, 32'd0, 32'd0, 32'd0);
		// zero period only comes due after the counter wraps
		send_request(ACT_MODIFY, 3'd3, 32'd0, 32'd0, 32'd0);
		send_request(ACT_MODIFY, 3'd4, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_request(ACT_STOP, 3'd0, 32'd0, 32'd0, 32'd0);
		send_request(ACT_START, 3'd0, 32'd1, $urandom() | 1, $urandom());
		send_request(ACT_TICK, 3'd0, 32'd0, 32'd0, 32'd0);
		send_request(ACT_TICK, 3'd0, 32'd0, 32'd0, 32'd0);
		send_request(ACT_STOP, 3'd7, 32'd0, 32'd0, 32'd0);
		send_request(ACT_STOP, 3'd6, 32'd0, 32'd0, 32'd0);
		send_request(ACT_TICK, 3'd0, 32'd0, 32'd0, 32'd0);

		// random traffic under each flow control mix
		run_random_phase(RANDOM_ITEMS / 4);
		idle_pct  = 82;
		stall_pct = 0;
		run_random_phase(RANDOM_ITEMS / 4);
		idle_pct  = 0;
		stall_pct = 82;
		run_random_phase(RANDOM_ITEMS / 4);
		idle_pct  = 17;
		stall_pct = 17;
		run_random_phase(RANDOM_ITEMS / 4);
		req.valid <= 1'b0;

		// drain outstanding results, then allow a final tick walk to finish
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_count == 0)
			$display("PASS periodic_soft_timer_bank");
		else
			$display("FAIL periodic_soft_timer_bank");
		$finish;
	end

endmodule
